>>> sv/ate_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the accelerometer tilt estimator.
// Depends on nothing; used by accel_tilt_estimator.
package ate_pkg;

  // Default generics
  localparam int CORDIC_STEPS_DEF     = 16;
  localparam int FILTER_FRAC_BITS_DEF = 8;

  // Configuration register map
  localparam int             CFG_IDX_W         = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_G  = 8'd1;
  localparam logic [15:0]    FILTER_WEIGHT_RST = 16'd55706;
  localparam logic [15:0]    COUNTS_PER_G_RST  = 16'd16384;

  // Fixed output scaling
  localparam int ANGLE_FRAC   = 16;
  localparam int ANGLE_LIMIT  = 9000;
  localparam int RATE_LIMIT   = 12728000;
  localparam int MS_PER_S     = 1000;
  localparam int MG_PER_G     = 1000;
  localparam int MG_MAX       = 65535;
  localparam int ATAN_ENTRIES = 24;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILT_A,
    ST_FILT_B,
    ST_FILT_C,
    ST_SQ_M,
    ST_SQ_W,
    ST_PITCH_GO,
    ST_PITCH_WT,
    ST_PITCH_CORD,
    ST_PITCH_END,
    ST_ROLL_GO,
    ST_ROLL_WT,
    ST_ROLL_CORD,
    ST_ROLL_END,
    ST_TILT_A,
    ST_TILT_B,
    ST_TILT_GO,
    ST_TILT_WT,
    ST_RATE_M,
    ST_RATE_GO,
    ST_RATE_WT,
    ST_MAG_GO,
    ST_MAG_WT,
    ST_MG_M,
    ST_MG_GO,
    ST_MG_WT,
    ST_DONE
  } seq_state_t;

  // atan(2^-i) in centidegrees with 16 fraction bits
  function automatic logic signed [31:0] atan_cdeg(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd294912000;
      5'd1:    v = 32'sd174096719;
      5'd2:    v = 32'sd91987925;
      5'd3:    v = 32'sd46694507;
      5'd4:    v = 32'sd23437865;
      5'd5:    v = 32'sd11730358;
      5'd6:    v = 32'sd5866610;
      5'd7:    v = 32'sd2933484;
      5'd8:    v = 32'sd1466764;
      5'd9:    v = 32'sd733385;
      5'd10:   v = 32'sd366693;
      5'd11:   v = 32'sd183346;
      5'd12:   v = 32'sd91673;
      5'd13:   v = 32'sd45837;
      5'd14:   v = 32'sd22918;
      5'd15:   v = 32'sd11459;
      5'd16:   v = 32'sd5730;
      5'd17:   v = 32'sd2865;
      5'd18:   v = 32'sd1432;
      5'd19:   v = 32'sd716;
      5'd20:   v = 32'sd358;
      5'd21:   v = 32'sd179;
      5'd22:   v = 32'sd90;
      5'd23:   v = 32'sd45;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/accel_tilt_estimator.sv
// Accelerometer tilt estimator top level: sequencer, filter state, CORDIC and shared multiplier.
// Depends on ate_pkg, ate_isqrt and ate_div.
//
// One sample beat is taken while the block is idle; the first sample after reset only loads
// the filter state and gives no result. Every later sample runs the low-pass filter, then
// pitch and roll (root plus vectoring CORDIC), tilt, tilt rate and magnitude, all through one
// multiplier, one bit-serial square root and one bit-serial divider under a sequencer. An item
// runs four root passes and two divide passes; a zero elapsed time skips the rate divide. A
// finished result waits in the output register while the next sample is already taken.
module accel_tilt_estimator #(
  parameter int CORDIC_STEPS     = ate_pkg::CORDIC_STEPS_DEF,
  parameter int FILTER_FRAC_BITS = ate_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  input  logic [15:0]          in_elapsed_ms,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_filtered_x,
  output logic signed [15:0]   out_filtered_y,
  output logic signed [15:0]   out_filtered_z,
  output logic signed [14:0]   out_pitch_cdeg,
  output logic signed [14:0]   out_roll_cdeg,
  output logic [13:0]          out_tilt_cdeg,
  output logic signed [24:0]   out_tilt_rate,
  output logic [15:0]          out_magnitude_counts,
  output logic [15:0]          out_magnitude_mg,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ate_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int F      = FILTER_FRAC_BITS;
  localparam int SW     = 16 + F;        // filter state
  localparam int MW     = 18 + F;        // multiplier operand
  localparam int PW     = 2 * MW;        // product
  localparam int NW     = 32 + 2 * F;    // root radicand
  localparam int RW     = NW / 2;        // root
  localparam int CW     = 19 + F;        // CORDIC x and y
  localparam int ZW     = 32;            // CORDIC angle
  localparam int DNW    = 27 + F;        // dividend
  localparam int DDW    = 16 + F;        // divisor
  localparam int CIW    = 5;
  localparam int FHALF  = (1 << F) >> 1;

  ate_pkg::seq_state_t state_r, state_nxt;

  logic [15:0]            w_r;
  logic [15:0]            cpg_r;
  logic                   primed_r;
  logic signed [SW-1:0]   st_r [3];
  logic signed [15:0]     raw_r [3];
  logic [15:0]            el_r;
  logic [1:0]             ax_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [PW-1:0]   acc_r;
  logic [NW-1:0]          sq_r [3];
  logic signed [CW-1:0]   cx_r, cy_r;
  logic signed [ZW-1:0]   cz_r;
  logic [CIW-1:0]         ci_r;
  logic                   czero_r;
  logic signed [14:0]     pitch_r, roll_r;
  logic [13:0]            tilt_r, prev_tilt_r;
  logic signed [24:0]     rate_r;
  logic [RW-1:0]          magq_r;
  logic [15:0]            cnt_r, mg_r;
  logic                   out_valid_r;
  logic signed [15:0]     ofx_r, ofy_r, ofz_r;
  logic signed [14:0]     opitch_r, oroll_r;
  logic [13:0]            otilt_r;
  logic signed [24:0]     orate_r;
  logic [15:0]            ocnt_r, omg_r;

  logic                   in_fire;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW:0]     facc;
  logic signed [CW-1:0]   xs, ys;
  logic signed [ZW-1:0]   zr;
  logic signed [14:0]     angle;
  logic signed [14:0]     tdiff;
  logic [14:0]            tabs;
  logic [DNW-1:0]         rq_sat;
  logic signed [SW:0]     fsum [3];
  logic [RW:0]            csum;
  logic [15:0]            cpg_eff;
  logic [DDW-1:0]         mg_den;

  logic                   sqrt_start, sqrt_done;
  logic [NW-1:0]          sqrt_n;
  logic [RW-1:0]          sqrt_root;
  logic [NW-1:0]          sqrt_rem;
  logic                   div_start, div_done;
  logic [DNW-1:0]         div_num;
  logic [DDW-1:0]         div_den;
  logic [DNW-1:0]         div_quo;

  assign in_ready  = (state_r == ate_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= ate_pkg::FILTER_WEIGHT_RST;
      cpg_r <= ate_pkg::COUNTS_PER_G_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ate_pkg::REG_FILTER_WEIGHT: w_r   <= cfg_data;
        ate_pkg::REG_COUNTS_PER_G:  cpg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ate_pkg::ST_FILT_A: begin
        mul_a = MW'({1'b0, w_r});
        mul_b = MW'(st_r[ax_r]);
      end
      ate_pkg::ST_FILT_B: begin
        mul_a = MW'(17'h10000 - {1'b0, w_r});
        mul_b = MW'(raw_r[ax_r]) <<< F;
      end
      ate_pkg::ST_SQ_M: begin
        mul_a = MW'(st_r[ax_r]);
        mul_b = MW'(st_r[ax_r]);
      end
      ate_pkg::ST_TILT_A: begin
        mul_a = MW'(pitch_r);
        mul_b = MW'(pitch_r);
      end
      ate_pkg::ST_TILT_B: begin
        mul_a = MW'(roll_r);
        mul_b = MW'(roll_r);
      end
      ate_pkg::ST_RATE_M: begin
        mul_a = MW'(tabs);
        mul_b = MW'(ate_pkg::MS_PER_S);
      end
      ate_pkg::ST_MG_M: begin
        mul_a = MW'(magq_r);
        mul_b = MW'(ate_pkg::MG_PER_G);
      end
      default: ;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Arithmetic around the shared units
  always_comb begin
    facc  = (PW+1)'(acc_r) + (PW+1)'(prod_r) + (PW+1)'(32'sd32768);
    xs    = cx_r >>> ci_r;
    ys    = cy_r >>> ci_r;
    zr    = (cz_r + ZW'(32'sd32768)) >>> ate_pkg::ANGLE_FRAC;
    if (czero_r) begin
      angle = '0;
    end else if (zr > ZW'(ate_pkg::ANGLE_LIMIT)) begin
      angle = 15'(ate_pkg::ANGLE_LIMIT);
    end else if (zr < -ZW'(ate_pkg::ANGLE_LIMIT)) begin
      angle = -15'(ate_pkg::ANGLE_LIMIT);
    end else begin
      angle = zr[14:0];
    end
    tdiff  = $signed({1'b0, tilt_r}) - $signed({1'b0, prev_tilt_r});
    tabs   = tdiff[14] ? 15'(-tdiff) : 15'(tdiff);
    rq_sat = (div_quo > DNW'(ate_pkg::RATE_LIMIT)) ? DNW'(ate_pkg::RATE_LIMIT) : div_quo;
    for (int i = 0; i < 3; i++) begin
      fsum[i] = (SW+1)'(st_r[i]) + (SW+1)'(FHALF);
    end
    csum    = {1'b0, sqrt_root} + (RW+1)'(FHALF);
    cpg_eff = (cpg_r == 16'd0) ? 16'd1 : cpg_r;
    mg_den  = DDW'(cpg_eff) << F;
  end

  // Root and divider requests
  always_comb begin
    sqrt_start = 1'b0;
    sqrt_n     = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (state_r)
      ate_pkg::ST_PITCH_GO: begin
        sqrt_start = 1'b1;
        sqrt_n     = sq_r[1] + sq_r[2];
      end
      ate_pkg::ST_ROLL_GO: begin
        sqrt_start = 1'b1;
        sqrt_n     = sq_r[0] + sq_r[2];
      end
      ate_pkg::ST_TILT_GO: begin
        sqrt_start = 1'b1;
        sqrt_n     = NW'(acc_r[31:0]) + NW'(prod_r[31:0]);
      end
      ate_pkg::ST_MAG_GO: begin
        sqrt_start = 1'b1;
        sqrt_n     = sq_r[0] + sq_r[1] + sq_r[2];
      end
      ate_pkg::ST_RATE_GO: begin
        div_start = 1'b1;
        div_num   = prod_r[DNW-1:0] + DNW'(el_r >> 1);
        div_den   = DDW'(el_r);
      end
      ate_pkg::ST_MG_GO: begin
        div_start = 1'b1;
        div_num   = prod_r[DNW-1:0] + DNW'(mg_den >> 1);
        div_den   = mg_den;
      end
      default: ;
    endcase
  end

  ate_isqrt #(.NW(NW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (sqrt_n),
    .done  (sqrt_done),
    .root  (sqrt_root),
    .rem   (sqrt_rem)
  );

  ate_div #(.NUMW(DNW), .DENW(DDW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ate_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ate_pkg::ST_IDLE:       if (in_fire && primed_r) state_nxt = ate_pkg::ST_FILT_A;
      ate_pkg::ST_FILT_A:     state_nxt = ate_pkg::ST_FILT_B;
      ate_pkg::ST_FILT_B:     state_nxt = ate_pkg::ST_FILT_C;
      ate_pkg::ST_FILT_C:     state_nxt = (ax_r == 2'd2) ? ate_pkg::ST_SQ_M : ate_pkg::ST_FILT_A;
      ate_pkg::ST_SQ_M:       state_nxt = ate_pkg::ST_SQ_W;
      ate_pkg::ST_SQ_W:       state_nxt = (ax_r == 2'd2) ? ate_pkg::ST_PITCH_GO : ate_pkg::ST_SQ_M;
      ate_pkg::ST_PITCH_GO:   state_nxt = ate_pkg::ST_PITCH_WT;
      ate_pkg::ST_PITCH_WT:   if (sqrt_done) state_nxt = ate_pkg::ST_PITCH_CORD;
      ate_pkg::ST_PITCH_CORD: begin
        if (ci_r == CIW'(CORDIC_STEPS - 1)) state_nxt = ate_pkg::ST_PITCH_END;
      end
      ate_pkg::ST_PITCH_END:  state_nxt = ate_pkg::ST_ROLL_GO;
      ate_pkg::ST_ROLL_GO:    state_nxt = ate_pkg::ST_ROLL_WT;
      ate_pkg::ST_ROLL_WT:    if (sqrt_done) state_nxt = ate_pkg::ST_ROLL_CORD;
      ate_pkg::ST_ROLL_CORD: begin
        if (ci_r == CIW'(CORDIC_STEPS - 1)) state_nxt = ate_pkg::ST_ROLL_END;
      end
      ate_pkg::ST_ROLL_END:   state_nxt = ate_pkg::ST_TILT_A;
      ate_pkg::ST_TILT_A:     state_nxt = ate_pkg::ST_TILT_B;
      ate_pkg::ST_TILT_B:     state_nxt = ate_pkg::ST_TILT_GO;
      ate_pkg::ST_TILT_GO:    state_nxt = ate_pkg::ST_TILT_WT;
      ate_pkg::ST_TILT_WT:    if (sqrt_done) state_nxt = ate_pkg::ST_RATE_M;
      ate_pkg::ST_RATE_M: begin
        state_nxt = (el_r == 16'd0) ? ate_pkg::ST_MAG_GO : ate_pkg::ST_RATE_GO;
      end
      ate_pkg::ST_RATE_GO:    state_nxt = ate_pkg::ST_RATE_WT;
      ate_pkg::ST_RATE_WT:    if (div_done) state_nxt = ate_pkg::ST_MAG_GO;
      ate_pkg::ST_MAG_GO:     state_nxt = ate_pkg::ST_MAG_WT;
      ate_pkg::ST_MAG_WT:     if (sqrt_done) state_nxt = ate_pkg::ST_MG_M;
      ate_pkg::ST_MG_M:       state_nxt = ate_pkg::ST_MG_GO;
      ate_pkg::ST_MG_GO:      state_nxt = ate_pkg::ST_MG_WT;
      ate_pkg::ST_MG_WT:      if (div_done) state_nxt = ate_pkg::ST_DONE;
      ate_pkg::ST_DONE:       if (!out_valid_r || out_ready) state_nxt = ate_pkg::ST_IDLE;
      default:                state_nxt = ate_pkg::ST_IDLE;
    endcase
  end

  // Control state kept across samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      prev_tilt_r <= '0;
      for (int i = 0; i < 3; i++) st_r[i] <= '0;
    end else begin
      if (in_fire && !primed_r) begin
        primed_r <= 1'b1;
        st_r[0]  <= SW'(in_accel_x) <<< F;
        st_r[1]  <= SW'(in_accel_y) <<< F;
        st_r[2]  <= SW'(in_accel_z) <<< F;
      end
      if (state_r == ate_pkg::ST_FILT_C) begin
        st_r[ax_r] <= facc[SW+15:16];
      end
      if ((state_r == ate_pkg::ST_RATE_M && el_r == 16'd0) ||
          (state_r == ate_pkg::ST_RATE_WT && div_done)) begin
        prev_tilt_r <= tilt_r;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ate_pkg::ST_IDLE: begin
        raw_r[0] <= in_accel_x;
        raw_r[1] <= in_accel_y;
        raw_r[2] <= in_accel_z;
        el_r     <= in_elapsed_ms;
        ax_r     <= 2'd0;
      end
      ate_pkg::ST_FILT_B: acc_r <= prod_r;
      ate_pkg::ST_FILT_C: ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      ate_pkg::ST_SQ_W: begin
        sq_r[ax_r] <= prod_r[NW-1:0];
        ax_r       <= ax_r + 2'd1;
      end
      ate_pkg::ST_PITCH_WT, ate_pkg::ST_ROLL_WT: begin
        cx_r    <= CW'(sqrt_root);
        cz_r    <= '0;
        ci_r    <= '0;
        if (state_r == ate_pkg::ST_PITCH_WT) begin
          cy_r    <= -CW'(st_r[0]);
          czero_r <= (st_r[0] == '0) && (sqrt_root == '0);
        end else begin
          cy_r    <= CW'(st_r[1]);
          czero_r <= (st_r[1] == '0) && (sqrt_root == '0);
        end
      end
      ate_pkg::ST_PITCH_CORD, ate_pkg::ST_ROLL_CORD: begin
        // rotate toward the x axis
        if (!cy_r[CW-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + ate_pkg::atan_cdeg(ci_r);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - ate_pkg::atan_cdeg(ci_r);
        end
        ci_r <= ci_r + CIW'(1);
      end
      ate_pkg::ST_PITCH_END: pitch_r <= angle;
      ate_pkg::ST_ROLL_END:  roll_r  <= angle;
      ate_pkg::ST_TILT_B:    acc_r   <= prod_r;
      ate_pkg::ST_TILT_WT: begin
        tilt_r <= (RW'(sqrt_rem) > sqrt_root) ? 14'(sqrt_root + RW'(1)) : 14'(sqrt_root);
      end
      ate_pkg::ST_RATE_M: if (el_r == 16'd0) rate_r <= '0;
      ate_pkg::ST_RATE_WT: begin
        rate_r <= tdiff[14] ? -25'(rq_sat) : 25'(rq_sat);
      end
      ate_pkg::ST_MAG_WT: begin
        magq_r <= sqrt_root;
        cnt_r  <= ((csum >> F) > (RW+1)'(16'hFFFF)) ? 16'hFFFF : 16'(csum >> F);
      end
      ate_pkg::ST_MG_WT: begin
        mg_r <= (div_quo > DNW'(ate_pkg::MG_MAX)) ? 16'(ate_pkg::MG_MAX) : div_quo[15:0];
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ate_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ate_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      ofx_r    <= 16'(fsum[0] >>> F);
      ofy_r    <= 16'(fsum[1] >>> F);
      ofz_r    <= 16'(fsum[2] >>> F);
      opitch_r <= pitch_r;
      oroll_r  <= roll_r;
      otilt_r  <= tilt_r;
      orate_r  <= rate_r;
      ocnt_r   <= cnt_r;
      omg_r    <= mg_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_filtered_x       = ofx_r;
  assign out_filtered_y       = ofy_r;
  assign out_filtered_z       = ofz_r;
  assign out_pitch_cdeg       = opitch_r;
  assign out_roll_cdeg        = oroll_r;
  assign out_tilt_cdeg        = otilt_r;
  assign out_tilt_rate        = orate_r;
  assign out_magnitude_counts = ocnt_r;
  assign out_magnitude_mg     = omg_r;

  // Checks
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_cdeg <= 15'sd9000 && out_pitch_cdeg >= -15'sd9000))
    else $error("pitch out of range");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tilt_cdeg <= 14'd12728))
    else $error("tilt out of range");

  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == ate_pkg::ST_PITCH_WT || state_r == ate_pkg::ST_ROLL_WT ||
                   state_r == ate_pkg::ST_TILT_WT || state_r == ate_pkg::ST_MAG_WT))
    else $error("root finished outside a wait state");

  a_prime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !primed_r) |=> (state_r == ate_pkg::ST_IDLE && primed_r))
    else $error("priming sample started work");

endmodule

>>> sv/ate_isqrt.sv
// Iterative integer square root, one result bit per cycle, with remainder.
// Standalone; instantiated by accel_tilt_estimator.
module ate_isqrt #(
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  output logic          done,
  output logic [NW/2-1:0] root,
  output logic [NW-1:0] rem
);

  localparam int RW   = NW / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   res_r;
  logic [NW-1:0]   bit_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [NW:0]     trial;
  logic            fits;

  // Try to subtract the current candidate
  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    fits  = {1'b0, rem_r} >= trial;
  end

  // Control: run RW steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one digit pair per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n;
      res_r <= '0;
      bit_r <= NW'(1) << (NW - 2);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - trial[NW-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[RW-1:0];
  assign rem  = rem_r;

endmodule

>>> sv/ate_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by accel_tilt_estimator.
module ate_div #(
  parameter int NUMW = 35,
  parameter int DENW = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic [NUMW-1:0] nq_r;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DENW:0]   shifted;
  logic            ge;
  logic [DENW:0]   diff;

  // Shift in the next numerator bit and compare
  always_comb begin
    shifted = {rem_r, nq_r[NUMW-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  // Control: run NUMW steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NUMW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter as numerator bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DENW-1:0] : shifted[DENW-1:0];
      nq_r  <= {nq_r[NUMW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule
